### src/assert_macros.svh
// Assertion macros shared by the period meter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DCPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define DCPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

### src/dcpm_pkg.sv
// Shared constants and types for the debounced crossing period meter.
// No dependencies; used by every RTL file but the skid and the macros.
package dcpm_pkg;

    // Default widths of the tick counter and converter samples
    localparam int TICK_WIDTH_DEFAULT   = 16;
    localparam int SAMPLE_WIDTH_DEFAULT = 12;

    // Debounce run counters and hit count register
    localparam int RUN_WIDTH = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE_HITS   = 2'd1;

    // Register reset values
    localparam int                   THRESHOLD_RESET = 512;
    localparam logic [RUN_WIDTH-1:0] HITS_RESET      = 8'd5;

    // Input item codes
    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    // Per-request control handed to the measurement core
    typedef struct packed {
        logic accept;
        logic action;
    } t_item_ctl;

endpackage

### src/dcpm_if.sv
// Handshake interfaces for the period meter channels.
// Uses dcpm_pkg for the configuration index width.
interface dcpm_in_if #(
    parameter int SAMPLE_WIDTH = dcpm_pkg::SAMPLE_WIDTH_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface dcpm_out_if #(
    parameter int TICK_WIDTH = dcpm_pkg::TICK_WIDTH_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [TICK_WIDTH-1:0] period_ticks;
    logic                  period_valid;
    logic                  indicator_on;

    modport source (output valid, output period_ticks, output period_valid,
                    output indicator_on, input ready);
    modport sink   (input valid, input period_ticks, input period_valid,
                    input indicator_on, output ready);
endinterface

interface dcpm_cfg_if #(
    parameter int DATA_WIDTH = dcpm_pkg::SAMPLE_WIDTH_DEFAULT
);
    logic                                  valid;
    logic                                  ready;
    logic [dcpm_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [DATA_WIDTH-1:0]                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/dcpm_cfg_regs.sv
// Configuration registers: level threshold and debounce hit count.
// Depends on dcpm_pkg and dcpm_cfg_if.
module dcpm_cfg_regs #(
    parameter int SAMPLE_WIDTH = dcpm_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dcpm_cfg_if.sink                       i_cfg,
    output logic [SAMPLE_WIDTH-1:0]        o_threshold,
    output logic [dcpm_pkg::RUN_WIDTH-1:0] o_hits
);

    logic [SAMPLE_WIDTH-1:0]        r_threshold;
    logic [dcpm_pkg::RUN_WIDTH-1:0] r_hits;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= SAMPLE_WIDTH'(dcpm_pkg::THRESHOLD_RESET);
            r_hits      <= dcpm_pkg::HITS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dcpm_pkg::CFG_LEVEL_THRESHOLD: begin
                    r_threshold <= i_cfg.data;
                end
                dcpm_pkg::CFG_DEBOUNCE_HITS: begin
                    r_hits <= i_cfg.data[dcpm_pkg::RUN_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_threshold = r_threshold;
    assign o_hits      = r_hits;

endmodule

### src/dcpm_core.sv
// Measurement core: tick counter, six-phase crossing machine, period sum.
// Depends on dcpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dcpm_core #(
    parameter int TICK_WIDTH   = dcpm_pkg::TICK_WIDTH_DEFAULT,
    parameter int SAMPLE_WIDTH = dcpm_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dcpm_pkg::t_item_ctl            i_ctl,
    input  logic [SAMPLE_WIDTH-1:0]        i_sample,
    input  logic [SAMPLE_WIDTH-1:0]        i_threshold,
    input  logic [dcpm_pkg::RUN_WIDTH-1:0] i_hits,
    output logic [TICK_WIDTH-1:0]          o_period_ticks,
    output logic                           o_period_valid,
    output logic                           o_indicator_on
);

    typedef enum logic [2:0] {
        PH_WAIT_FALL = 3'd0,
        PH_DEB_FALL  = 3'd1,
        PH_FELL      = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_DEB_RISE  = 3'd4,
        PH_ROSE      = 3'd5
    } t_phase;

    localparam logic [dcpm_pkg::RUN_WIDTH-1:0] RUN_ONE = dcpm_pkg::RUN_WIDTH'(1);

    t_phase                         r_phase, n_phase;
    logic [dcpm_pkg::RUN_WIDTH-1:0] r_low_run, n_low_run;
    logic [dcpm_pkg::RUN_WIDTH-1:0] r_high_run, n_high_run;
    logic [TICK_WIDTH-1:0]          r_tick_counter, n_tick_counter;
    logic [TICK_WIDTH-1:0]          r_first_half, n_first_half;
    logic                           r_indicator, n_indicator;

    logic                           w_below;
    logic [dcpm_pkg::RUN_WIDTH-1:0] w_low_bump, w_high_bump;
    logic [TICK_WIDTH-1:0]          w_period;
    logic                           w_period_valid;

    assign w_below = i_sample < i_threshold;

    // Saturating run increments
    assign w_low_bump  = (r_low_run == '1)  ? r_low_run  : r_low_run + RUN_ONE;
    assign w_high_bump = (r_high_run == '1) ? r_high_run : r_high_run + RUN_ONE;

    // Next state for one request
    always_comb begin
        n_phase        = r_phase;
        n_low_run      = r_low_run;
        n_high_run     = r_high_run;
        n_tick_counter = r_tick_counter;
        n_first_half   = r_first_half;
        n_indicator    = r_indicator;
        w_period       = '0;
        w_period_valid = 1'b0;
        if (i_ctl.accept) begin
            if (i_ctl.action == dcpm_pkg::ACTION_TICK) begin
                n_tick_counter = r_tick_counter + TICK_WIDTH'(1);
            end else begin
                case (r_phase)
                    PH_WAIT_FALL: begin
                        if (w_below) begin
                            n_phase    = PH_DEB_FALL;
                            n_low_run  = RUN_ONE;
                            n_high_run = '0;
                        end
                    end
                    PH_DEB_FALL: begin
                        if (w_below) begin
                            n_low_run = w_low_bump;
                            if (w_low_bump >= i_hits) begin
                                n_phase = PH_FELL;
                            end
                        end else begin
                            n_low_run = '0;
                        end
                    end
                    PH_FELL: begin
                        n_first_half   = r_tick_counter;
                        n_tick_counter = '0;
                        n_indicator    = 1'b1;
                        n_phase        = PH_WAIT_RISE;
                    end
                    PH_WAIT_RISE: begin
                        if (!w_below) begin
                            n_phase    = PH_DEB_RISE;
                            n_low_run  = '0;
                            n_high_run = RUN_ONE;
                        end
                    end
                    PH_DEB_RISE: begin
                        if (!w_below) begin
                            n_high_run = w_high_bump;
                            if (w_high_bump >= i_hits) begin
                                n_phase = PH_ROSE;
                            end
                        end else begin
                            n_high_run = '0;
                        end
                    end
                    PH_ROSE: begin
                        n_indicator    = 1'b0;
                        w_period       = r_tick_counter + r_first_half;
                        w_period_valid = 1'b1;
                        n_tick_counter = '0;
                        n_phase        = PH_WAIT_FALL;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT_FALL;
            r_low_run      <= '0;
            r_high_run     <= '0;
            r_tick_counter <= '0;
            r_first_half   <= '0;
            r_indicator    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_low_run      <= n_low_run;
            r_high_run     <= n_high_run;
            r_tick_counter <= n_tick_counter;
            r_first_half   <= n_first_half;
            r_indicator    <= n_indicator;
        end
    end

    // Result of this request, registered in the output stage
    assign o_period_ticks = w_period;
    assign o_period_valid = w_period_valid;
    assign o_indicator_on = n_indicator;

    // Indicator is lit exactly in the rising half of the cycle
    `DCPM_ASSERT(a_indicator_phase, i_clk, i_rst_n,
        r_indicator == ((r_phase == PH_WAIT_RISE) || (r_phase == PH_DEB_RISE)
                        || (r_phase == PH_ROSE)), "indicator out of step with phase")
    // A reported period always comes with the indicator off
    `DCPM_ASSERT(a_period_dark, i_clk, i_rst_n,
        o_period_valid |-> !o_indicator_on, "period reported with indicator on")
    // Completing a measurement restarts the tick count
    `DCPM_ASSERT(a_rose_clears, i_clk, i_rst_n,
        o_period_valid |=> (r_tick_counter == '0) && (r_phase == PH_WAIT_FALL),
        "counter not cleared after period")

endmodule

### src/dcpm_skid.sv
// Output register with a skid stage; the skid absorbs one request under stall.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dcpm_skid #(
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop_ready
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_drain;

    assign w_drain = !r_out_valid || i_pop_ready;

    // Control: output register refills from skid first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_drain) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Skid only ever holds a request behind a waiting output
    `DCPM_ASSERT(a_skid_behind_out, i_clk, i_rst_n,
        r_skid_valid |-> r_out_valid, "skid holds data with empty output")
    // A stalled output with a push fills the skid
    `DCPM_ASSERT(a_stall_fills, i_clk, i_rst_n,
        (r_out_valid && !i_pop_ready && i_push) |=> r_skid_valid,
        "request lost on output stall")

endmodule

### src/debounced_crossing_period_meter_unit.sv
// Top level of the debounced crossing period meter.
// Depends on dcpm_pkg, dcpm_if, dcpm_cfg_regs, dcpm_core and dcpm_skid.
//
//  channel  dir  modport  payload
//  -------  ---  -------  -----------------------------------------------
//  i_in     in   sink     action, sample[SAMPLE_WIDTH-1:0]
//  o_out    out  source   period_ticks[TICK_WIDTH-1:0], period_valid,
//                         indicator_on
//  i_cfg    in   sink     index[1:0] (0 threshold, 1 hits), data
//
// One request per cycle while i_in.ready is high; each yields exactly one result
// in the output register. The per-request work is a compare, a run increment and
// a tick add in the core. Synchronous active-low reset restores the register
// defaults and the idle phase. A stalled output spills one result into the skid
// stage; i_in.ready drops only while the skid is occupied.
module debounced_crossing_period_meter_unit #(
    parameter int TICK_WIDTH   = dcpm_pkg::TICK_WIDTH_DEFAULT,
    parameter int SAMPLE_WIDTH = dcpm_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcpm_in_if.sink     i_in,
    dcpm_out_if.source  o_out,
    dcpm_cfg_if.sink    i_cfg
);

    localparam int RESULT_WIDTH = TICK_WIDTH + 2;

    dcpm_pkg::t_item_ctl            w_ctl;
    logic [SAMPLE_WIDTH-1:0]        w_threshold;
    logic [dcpm_pkg::RUN_WIDTH-1:0] w_hits;
    logic [TICK_WIDTH-1:0]          w_period_ticks;
    logic                           w_period_valid;
    logic                           w_indicator_on;
    logic                           w_ready;
    logic [RESULT_WIDTH-1:0]        w_result;
    logic [RESULT_WIDTH-1:0]        w_out_data;

    dcpm_cfg_regs #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_threshold (w_threshold),
        .o_hits      (w_hits)
    );

    // Input handshake
    assign i_in.ready   = w_ready;
    assign w_ctl.accept = i_in.valid && w_ready;
    assign w_ctl.action = i_in.action;

    dcpm_core #(
        .TICK_WIDTH   (TICK_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_sample       (i_in.sample),
        .i_threshold    (w_threshold),
        .i_hits         (w_hits),
        .o_period_ticks (w_period_ticks),
        .o_period_valid (w_period_valid),
        .o_indicator_on (w_indicator_on)
    );

    assign w_result = {w_period_ticks, w_period_valid, w_indicator_on};

    dcpm_skid #(
        .WIDTH (RESULT_WIDTH)
    ) u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_ctl.accept),
        .i_data      (w_result),
        .o_ready     (w_ready),
        .o_valid     (o_out.valid),
        .o_data      (w_out_data),
        .i_pop_ready (o_out.ready)
    );

    // Result fields
    assign o_out.period_ticks = w_out_data[RESULT_WIDTH-1:2];
    assign o_out.period_valid = w_out_data[1];
    assign o_out.indicator_on = w_out_data[0];

endmodule

### tb/tb_top.sv
// Self-checking testbench for debounced_crossing_period_meter_unit.
// Depends on dcpm_pkg and the dcpm_if interfaces; predicts every result
// in a scoreboard class, gaps the input and stalls the output at random.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_W      = dcpm_pkg::TICK_WIDTH_DEFAULT;
    localparam int SAMPLE_W    = dcpm_pkg::SAMPLE_WIDTH_DEFAULT;
    localparam int RUN_W       = dcpm_pkg::RUN_WIDTH;
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_HOLD  = 11;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYC  = 4;

    // Measurement phases, in the order the block walks them
    typedef enum logic [2:0] {
        PH_WAIT_LOW, PH_COUNT_LOW, PH_LATCH_FALL,
        PH_WAIT_HIGH, PH_COUNT_HIGH, PH_LATCH_RISE
    } t_crossing_phase;

    typedef struct {
        logic [TICK_W-1:0] period_ticks;
        logic              period_valid;
        logic              indicator_on;
    } t_meter_reading;

    // Predicts one reading per request and checks readings in order
    class t_meter_scoreboard;
        logic [SAMPLE_W-1:0] threshold;
        logic [RUN_W-1:0]    hits;
        t_crossing_phase     phase;
        logic [RUN_W-1:0]    low_run;
        logic [RUN_W-1:0]    high_run;
        logic [TICK_W-1:0]   tick_count;
        logic [TICK_W-1:0]   first_half;
        logic                indicator;
        t_meter_reading      pending_readings[$];
        int                  error_count;
        int                  period_count;
        int                  write_count;

        function new();
            threshold    = SAMPLE_W'(dcpm_pkg::THRESHOLD_RESET);
            hits         = dcpm_pkg::HITS_RESET;
            phase        = PH_WAIT_LOW;
            low_run      = '0;
            high_run     = '0;
            tick_count   = '0;
            first_half   = '0;
            indicator    = 1'b0;
            error_count  = 0;
            period_count = 0;
            write_count  = 0;
        endfunction

        function void set_register(logic [dcpm_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                   logic [SAMPLE_W-1:0] value);
            write_count++;
            if (idx == dcpm_pkg::CFG_LEVEL_THRESHOLD) begin
                threshold = value;
            end else if (idx == dcpm_pkg::CFG_DEBOUNCE_HITS) begin
                hits = value[RUN_W-1:0];
            end
        endfunction

        function void note_request(logic act, logic [SAMPLE_W-1:0] smp);
            t_meter_reading r;
            logic           below;
            r.period_ticks = '0;
            r.period_valid = 1'b0;
            below = smp < threshold;
            if (act == dcpm_pkg::ACTION_TICK) begin
                tick_count = tick_count + 1'b1;
            end else begin
                case (phase)
                    PH_WAIT_LOW: begin
                        if (below) begin
                            phase    = PH_COUNT_LOW;
                            low_run  = 8'd1;
                            high_run = '0;
                        end
                    end
                    PH_COUNT_LOW: begin
                        if (below) begin
                            // run counters saturate instead of wrapping
                            if (low_run != '1) low_run = low_run + 1'b1;
                            if (low_run >= hits) phase = PH_LATCH_FALL;
                        end else begin
                            low_run = '0;
                        end
                    end
                    PH_LATCH_FALL: begin
                        first_half = tick_count;
                        tick_count = '0;
                        indicator  = 1'b1;
                        phase      = PH_WAIT_HIGH;
                    end
                    PH_WAIT_HIGH: begin
                        if (!below) begin
                            phase    = PH_COUNT_HIGH;
                            low_run  = '0;
                            high_run = 8'd1;
                        end
                    end
                    PH_COUNT_HIGH: begin
                        if (!below) begin
                            if (high_run != '1) high_run = high_run + 1'b1;
                            if (high_run >= hits) phase = PH_LATCH_RISE;
                        end else begin
                            high_run = '0;
                        end
                    end
                    PH_LATCH_RISE: begin
                        indicator      = 1'b0;
                        r.period_ticks = tick_count + first_half;
                        r.period_valid = 1'b1;
                        tick_count     = '0;
                        phase          = PH_WAIT_LOW;
                        period_count++;
                    end
                    default: begin
                    end
                endcase
            end
            r.indicator_on = indicator;
            pending_readings.push_back(r);
        endfunction

        function void check_result(logic [TICK_W-1:0] ticks, logic pvalid, logic ind);
            t_meter_reading exp_r;
            if (pending_readings.size() == 0) begin
                $error("unexpected result: period_ticks %0d, period_valid %0d, indicator_on %0d",
                       ticks, pvalid, ind);
                error_count++;
            end else begin
                exp_r = pending_readings.pop_front();
                if (ticks !== exp_r.period_ticks) begin
                    $error("period_ticks: expected %0d, actual %0d", exp_r.period_ticks, ticks);
                    error_count++;
                end
                if (pvalid !== exp_r.period_valid) begin
                    $error("period_valid: expected %0d, actual %0d", exp_r.period_valid, pvalid);
                    error_count++;
                end
                if (ind !== exp_r.indicator_on) begin
                    $error("indicator_on: expected %0d, actual %0d", exp_r.indicator_on, ind);
                    error_count++;
                end
            end
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dcpm_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
    dcpm_out_if #(.TICK_WIDTH(TICK_W))     out_if ();
    dcpm_cfg_if #(.DATA_WIDTH(SAMPLE_W))   cfg_if ();

    debounced_crossing_period_meter_unit #(
        .TICK_WIDTH   (TICK_W),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_meter_scoreboard meter_sb = new();

    // Stimulus-side copy of the live settings, used to shape samples
    logic [SAMPLE_W-1:0] cur_threshold = SAMPLE_W'(dcpm_pkg::THRESHOLD_RESET);
    logic [RUN_W-1:0]    cur_hits      = dcpm_pkg::HITS_RESET;
    bit                  gaps_on       = 1'b1;
    int                  sent_count    = 0;
    int                  settings_count = 1;
    int                  send_quiet    = 0;
    int                  recv_quiet    = 0;
    int                  idle_cycles   = 0;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Gap length: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap(ref int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic act, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = gaps_on ? pick_gap(send_quiet) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= act;
        in_if.sample <= smp;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(dcpm_pkg::ACTION_TICK, SAMPLE_W'($urandom));
    endtask

    task automatic send_level(input bit low);
        logic [SAMPLE_W-1:0] smp;
        if (low) begin
            // nothing reads as low under a zero threshold
            smp = (cur_threshold == '0) ? '0 : SAMPLE_W'($urandom_range(0, cur_threshold - 1));
        end else begin
            smp = SAMPLE_W'($urandom_range(cur_threshold, (1 << SAMPLE_W) - 1));
        end
        send_request(dcpm_pkg::ACTION_SAMPLE, smp);
    endtask

    // One debounced crossing with ticks mixed in, sometimes broken by a glitch
    task automatic send_crossing(input bit low);
        int n;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, (cur_hits == 0) ? 1 : cur_hits)) send_level(low);
            send_level(!low);
        end
        n = cur_hits + $urandom_range(1, 2);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(1, 4));
            if ($urandom_range(0, 63) == 0) send_ticks($urandom_range(20, 40));
            send_level(low);
        end
        // latch request: its value is ignored
        send_request(dcpm_pkg::ACTION_SAMPLE, SAMPLE_W'($urandom));
    endtask

    task automatic run_mixed(input int budget);
        int start;
        start = sent_count;
        while (sent_count - start < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                send_crossing(1'b1);
                send_crossing(1'b0);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(logic'($urandom_range(0, 1)), SAMPLE_W'($urandom));
            end
        end
    endtask

    // Drop valid and wait until every predicted reading has come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (meter_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write both registers back to back; valid stays high across the pair
    task automatic apply_settings(input logic [SAMPLE_W-1:0] thr, input logic [RUN_W-1:0] h);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= dcpm_pkg::CFG_LEVEL_THRESHOLD;
        cfg_if.data  <= thr;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.index <= dcpm_pkg::CFG_DEBOUNCE_HITS;
        cfg_if.data  <= SAMPLE_W'(h);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid  <= 1'b0;
        cur_threshold  = thr;
        cur_hits       = h;
        settings_count++;
    endtask

    // Directed walk at reset settings: ignored fields, bounds, broken debounce
    task automatic run_directed();
        send_request(dcpm_pkg::ACTION_TICK, '1);
        send_request(dcpm_pkg::ACTION_TICK, '0);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd512);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd4095);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd511);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd100);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd600);
        repeat (5) send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
        send_ticks(2);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd4095);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd512);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd4095);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd511);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd512);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd600);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd700);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd800);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd900);
        send_ticks(1);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
    endtask

    // Long halves sent back to back with no input gaps
    task automatic run_wrap();
        gaps_on = 1'b0;
        repeat (5) send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
        send_ticks(40);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd0);
        repeat (5) send_request(dcpm_pkg::ACTION_SAMPLE, 12'd4095);
        send_ticks(30);
        send_request(dcpm_pkg::ACTION_SAMPLE, 12'd4095);
        gaps_on = 1'b1;
    endtask

    // Output side: random back-pressure
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_gap(recv_quiet);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Main sequence
    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.action <= dcpm_pkg::ACTION_SAMPLE;
        in_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= dcpm_pkg::CFG_LEVEL_THRESHOLD;
        cfg_if.data  <= '0;
        repeat (RESET_HOLD) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_wrap();
        wait_drained();

        apply_settings(12'd2048, 8'd3);
        run_mixed(150);
        wait_drained();
        apply_settings(12'd4095, 8'd1);
        run_mixed(100);
        wait_drained();
        apply_settings(12'd0, 8'd8);
        run_mixed(60);
        wait_drained();
        // zero hits: an edge is taken on the first debounce sample
        apply_settings(12'd1, 8'd0);
        run_mixed(100);
        wait_drained();
        // longest debounce: one full measurement
        apply_settings(12'd3000, 8'd255);
        send_crossing(1'b1);
        send_crossing(1'b0);
        wait_drained();
        repeat (2) begin
            apply_settings(SAMPLE_W'($urandom), RUN_W'($urandom_range(1, 12)));
            run_mixed(80);
            wait_drained();
        end

        $display("Covered %0d requests and %0d register writes over %0d settings,",
                 sent_count, meter_sb.write_count, settings_count);
        $display("with %0d periods reported and %0d mismatches.",
                 meter_sb.period_count, meter_sb.error_count);
        if (meter_sb.error_count == 0 && meter_sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Monitor: register writes, requests, results, and the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                meter_sb.set_register(cfg_if.index, cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                meter_sb.note_request(in_if.action, in_if.sample);
            end
            if (out_if.valid && out_if.ready) begin
                meter_sb.check_result(out_if.period_ticks, out_if.period_valid,
                                      out_if.indicator_on);
            end
            if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
                (out_if.valid && out_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

### files.f
+incdir+src
src/dcpm_pkg.sv
src/dcpm_if.sv
src/dcpm_cfg_regs.sv
src/dcpm_core.sv
src/dcpm_skid.sv
src/debounced_crossing_period_meter_unit.sv
tb/tb_top.sv
